FILE: rtl/nll_pkg.sv
// ----------------------------------------------------------------------------
// nll_pkg: shared definitions for the nonlinear ladder low-pass filter
// Register map, clamp limits, microcode encoding, the control program and
// the elaboration-time tanh step used to build the lookup table.
// ----------------------------------------------------------------------------
package nll_pkg;

  localparam int OVERSAMPLE_DEF      = 2;
  localparam int TANH_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 24;

  localparam logic [1:0] REG_CUTOFF = 2'd0;
  localparam logic [1:0] REG_RES    = 2'd1;
  localparam logic [1:0] REG_DRIVE  = 2'd2;

  localparam logic [15:0] CUTOFF_RESET = 16'd15178;
  localparam logic [15:0] RES_RESET    = 16'd8192;
  localparam logic [15:0] DRIVE_RESET  = 16'd4096;
  localparam logic [15:0] RES_MAX      = 16'd40960;
  localparam logic [15:0] DRIVE_MIN    = 16'd410;
  localparam logic [15:0] DRIVE_MAX    = 16'd40960;

  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;
  localparam logic [3:0] OP_MUL_DRV = 4'd2;
  localparam logic [3:0] OP_ARG_DRV = 4'd3;
  localparam logic [3:0] OP_TH_RD   = 4'd4;
  localparam logic [3:0] OP_TH_MUL  = 4'd5;
  localparam logic [3:0] OP_TH_FIN  = 4'd6;
  localparam logic [3:0] OP_SET_U   = 4'd7;
  localparam logic [3:0] OP_MUL_RES = 4'd8;
  localparam logic [3:0] OP_ARG_FB  = 4'd9;
  localparam logic [3:0] OP_SET_TGT = 4'd10;
  localparam logic [3:0] OP_MUL_G   = 4'd11;
  localparam logic [3:0] OP_UPD     = 4'd12;
  localparam logic [3:0] OP_PASS    = 4'd13;
  localparam logic [3:0] OP_OUT     = 4'd14;

  localparam logic [1:0] W_NONE = 2'd0;
  localparam logic [1:0] W_IN   = 2'd1;
  localparam logic [1:0] W_OUT  = 2'd2;

  localparam logic [1:0] J_NONE   = 2'd0;
  localparam logic [1:0] J_ALWAYS = 2'd1;
  localparam logic [1:0] J_LAST   = 2'd2;
  localparam logic [1:0] J_MORE   = 2'd3;

  localparam logic [4:0] PC_IDLE   = 5'd0;
  localparam logic [4:0] PC_PASS   = 5'd7;
  localparam logic [4:0] PC_FOLLOW = 5'd13;
  localparam logic [4:0] PC_END    = 5'd22;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] wait_c;
    logic [1:0] jmp_c;
    logic [4:0] target;
  } ucode_t;

  function automatic ucode_t uw(input logic [3:0] op, input logic [1:0] wt,
                                input logic [1:0] jc, input logic [4:0] tgt);
    ucode_t w;
    w.op     = op;
    w.wait_c = wt;
    w.jmp_c  = jc;
    w.target = tgt;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [4:0] pc);
    ucode_t w;
    case (pc)
      5'd0:  w = uw(OP_LOAD,    W_IN,   J_NONE,   PC_IDLE);
      5'd1:  w = uw(OP_MUL_DRV, W_NONE, J_NONE,   PC_IDLE);
      5'd2:  w = uw(OP_ARG_DRV, W_NONE, J_NONE,   PC_IDLE);
      5'd3:  w = uw(OP_TH_RD,   W_NONE, J_NONE,   PC_IDLE);
      5'd4:  w = uw(OP_TH_MUL,  W_NONE, J_NONE,   PC_IDLE);
      5'd5:  w = uw(OP_TH_FIN,  W_NONE, J_NONE,   PC_IDLE);
      5'd6:  w = uw(OP_SET_U,   W_NONE, J_NONE,   PC_IDLE);
      5'd7:  w = uw(OP_MUL_RES, W_NONE, J_NONE,   PC_IDLE);
      5'd8:  w = uw(OP_ARG_FB,  W_NONE, J_NONE,   PC_IDLE);
      5'd9:  w = uw(OP_TH_RD,   W_NONE, J_NONE,   PC_IDLE);
      5'd10: w = uw(OP_TH_MUL,  W_NONE, J_NONE,   PC_IDLE);
      5'd11: w = uw(OP_TH_FIN,  W_NONE, J_NONE,   PC_IDLE);
      5'd12: w = uw(OP_SET_TGT, W_NONE, J_NONE,   PC_IDLE);
      5'd13: w = uw(OP_TH_RD,   W_NONE, J_NONE,   PC_IDLE);
      5'd14: w = uw(OP_TH_MUL,  W_NONE, J_NONE,   PC_IDLE);
      5'd15: w = uw(OP_TH_FIN,  W_NONE, J_NONE,   PC_IDLE);
      5'd16: w = uw(OP_MUL_G,   W_NONE, J_NONE,   PC_IDLE);
      5'd17: w = uw(OP_UPD,     W_NONE, J_LAST,   PC_END);
      5'd18: w = uw(OP_TH_RD,   W_NONE, J_NONE,   PC_IDLE);
      5'd19: w = uw(OP_TH_MUL,  W_NONE, J_NONE,   PC_IDLE);
      5'd20: w = uw(OP_TH_FIN,  W_NONE, J_NONE,   PC_IDLE);
      5'd21: w = uw(OP_SET_TGT, W_NONE, J_ALWAYS, PC_FOLLOW);
      5'd22: w = uw(OP_PASS,    W_NONE, J_MORE,   PC_PASS);
      5'd23: w = uw(OP_OUT,     W_OUT,  J_ALWAYS, PC_IDLE);
      default: w = uw(OP_NOP,   W_NONE, J_ALWAYS, PC_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // tanh of one table step in Q30 from a four-term series.
  function automatic logic [63:0] tanh_step(input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] x3;
    logic [63:0] x5;
    logic [63:0] x7;
    x  = 64'd1 << (33 - bits);
    x2 = mul_q30(x, x);
    x3 = mul_q30(x2, x);
    x5 = mul_q30(x3, x2);
    x7 = mul_q30(x5, x2);
    return x - x3 / 64'd3 + (64'd2 * x5) / 64'd15 - (64'd17 * x7) / 64'd315;
  endfunction

endpackage

FILE: rtl/nonlinear_ladder_lowpass.sv
// A request is taken only while the microcoded program is idle, and a new one only after the
// previous sample has been run through the whole program; the program runs all tanh lookups and
// products through one shared multiplier.
// Reset: synchronous, active low; registers return to defaults and ladder states to zero.
// After reset the tanh table is built with one 31-step division for each entry but the first,
// which is written as zero; in_tready stays low until it is done.
// ----------------------------------------------------------------------------
// nonlinear_ladder_lowpass: four-stage nonlinear ladder low-pass filter
// A microcoded sequencer drives a small datapath with one multiplier and a
// table-based tanh unit to run the oversampled ladder on each sample.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass #(
  parameter int OVERSAMPLE      = nll_pkg::OVERSAMPLE_DEF,
  parameter int TANH_TABLE_BITS = nll_pkg::TANH_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = nll_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [3:0]                            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int TDW    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int TAB_N  = 1 << TANH_TABLE_BITS;
  localparam int AB     = TANH_TABLE_BITS + 1;
  localparam int TAB_SH = 26 - TANH_TABLE_BITS;
  localparam int IN_UP  = (SAMPLE_BITS < 24) ? (24 - SAMPLE_BITS) : 0;
  localparam int IN_DN  = (SAMPLE_BITS > 24) ? (SAMPLE_BITS - 24) : 0;
  localparam int AW     = 37;
  localparam int MAW    = 34;
  localparam int MBW    = (TAB_SH + 1 > 17) ? (TAB_SH + 1) : 17;
  localparam int MPW    = MAW + MBW;
  localparam int PW     = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam logic [PW-1:0] P_LAST = PW'(OVERSAMPLE - 1);
  localparam logic [30:0] T_STEP = 31'(nll_pkg::tanh_step(TANH_TABLE_BITS));
  localparam logic signed [33:0] S32MAX = 34'sd2147483647;
  localparam logic signed [33:0] S32MIN = -34'sd2147483648;
  localparam logic signed [47:0] OMAX = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
  localparam logic signed [47:0] OMIN = -(48'sd1 <<< (SAMPLE_BITS - 1));

  localparam logic [2:0] B_ZERO = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_DEN  = 3'd2;
  localparam logic [2:0] B_LOAD = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_WR   = 3'd5;
  localparam logic [2:0] B_DONE = 3'd6;

  function automatic logic signed [MPW-1:0] rnd_sh(input logic signed [MPW-1:0] v,
                                                   input int sh);
    logic signed [MPW-1:0] half;
    half = $signed(MPW'(1) << (sh - 1));
    return (v + half) >>> sh;
  endfunction

  // Configuration registers.
  logic [15:0] cutoff_r, res_r, drive_r;
  logic        cfg_wr;
  logic [15:0] wdat;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign wdat       = cfg_pwdata[15:0];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= nll_pkg::CUTOFF_RESET;
      res_r    <= nll_pkg::RES_RESET;
      drive_r  <= nll_pkg::DRIVE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        nll_pkg::REG_CUTOFF: cutoff_r <= wdat;
        nll_pkg::REG_RES: begin
          res_r <= (wdat > nll_pkg::RES_MAX) ? nll_pkg::RES_MAX : wdat;
        end
        nll_pkg::REG_DRIVE: begin
          drive_r <= (wdat > nll_pkg::DRIVE_MAX) ? nll_pkg::DRIVE_MAX :
                     (wdat < nll_pkg::DRIVE_MIN) ? nll_pkg::DRIVE_MIN : wdat;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      nll_pkg::REG_CUTOFF: cfg_prdata = 32'(cutoff_r);
      nll_pkg::REG_RES:    cfg_prdata = 32'(res_r);
      nll_pkg::REG_DRIVE:  cfg_prdata = 32'(drive_r);
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // Table build after reset.
  logic [2:0]    bst_r, bst_nxt;
  logic [AB-1:0] bk_r, bk_nxt;
  logic [30:0]   cur_r, cur_nxt;
  logic [61:0]   bprod_r, bprod_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [30:0]   rem_r, rem_nxt;
  logic [30:0]   quo_r, quo_nxt;
  logic [4:0]    dcnt_r, dcnt_nxt;
  logic [61:0]   dvd;
  logic [61:0]   dvd_full;
  logic [32:0]   trial;
  logic [31:0]   rnd_q;
  logic          we;
  logic [AB-1:0] waddr;
  logic [23:0]   wval;
  logic          built;

  assign built    = (bst_r == B_DONE);
  assign dvd      = (62'(cur_r) + 62'(T_STEP)) << 30;
  assign dvd_full = dvd + 62'(den_r >> 1);
  assign trial    = {1'b0, rem_r, quo_r[30]} - {1'b0, den_r};
  assign rnd_q    = 32'(quo_r) + 32'd64;

  always_comb begin
    bst_nxt   = bst_r;
    bk_nxt    = bk_r;
    cur_nxt   = cur_r;
    bprod_nxt = bprod_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dcnt_nxt  = dcnt_r;
    we        = 1'b0;
    waddr     = bk_r;
    wval      = rnd_q[30:7];
    case (bst_r)
      B_ZERO: begin
        we      = 1'b1;
        waddr   = '0;
        wval    = '0;
        bk_nxt  = AB'(1);
        cur_nxt = '0;
        bst_nxt = B_MUL;
      end
      B_MUL: begin
        bprod_nxt = 62'(cur_r) * 62'(T_STEP);
        bst_nxt   = B_DEN;
      end
      B_DEN: begin
        den_nxt = 32'h4000_0000 + 32'((bprod_r + 62'h2000_0000) >> 30);
        bst_nxt = B_LOAD;
      end
      B_LOAD: begin
        rem_nxt  = dvd_full[61:31];
        quo_nxt  = dvd_full[30:0];
        dcnt_nxt = '0;
        bst_nxt  = B_DIV;
      end
      B_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial[30:0];
        end else begin
          rem_nxt = {rem_r[29:0], quo_r[30]};
        end
        quo_nxt  = {quo_r[29:0], ~trial[32]};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd30) begin
          bst_nxt = B_WR;
        end
      end
      B_WR: begin
        we      = 1'b1;
        cur_nxt = quo_r;
        bk_nxt  = bk_r + AB'(1);
        bst_nxt = (bk_r == AB'(TAB_N)) ? B_DONE : B_MUL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r <= B_ZERO;
    end else begin
      bst_r <= bst_nxt;
    end
    bk_r    <= bk_nxt;
    cur_r   <= cur_nxt;
    bprod_r <= bprod_nxt;
    den_r   <= den_nxt;
    dcnt_r  <= dcnt_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
  end

  // Microcoded datapath.
  logic [4:0]            pc_r, pc_nxt;
  nll_pkg::ucode_t       uc;
  logic                  hold, jmp, exec, in_acc;
  logic [1:0]            k_r, k_nxt;
  logic [PW-1:0]         p_r, p_nxt;
  logic signed [23:0]    x_r, x_nxt;
  logic signed [AW-1:0]  arg_r, arg_nxt;
  logic signed [MPW-1:0] prod_r, prod_nxt;
  logic                  neg_r, neg_nxt;
  logic [TAB_SH-1:0]     frac_r, frac_nxt;
  logic signed [24:0]    th_r, th_nxt;
  logic signed [24:0]    u_r, u_nxt;
  logic signed [24:0]    tgt_r, tgt_nxt;
  logic signed [31:0]    st_r [4];
  logic signed [31:0]    st_nxt [4];
  logic signed [31:0]    s4p_r, s4p_nxt;
  logic                  ov_r, ov_nxt;
  logic [SAMPLE_BITS-1:0] od_r, od_nxt;

  logic [23:0]           mem [0:TAB_N];
  logic [23:0]           rd0_r, rd1_r;
  logic [AB-1:0]         ra0, ra1;
  logic [AW-1:0]         a_abs;
  logic                  sat_idx;

  logic signed [MAW-1:0] ma;
  logic signed [MBW-1:0] mb;
  logic signed [MPW-1:0] mul_p;
  logic signed [MPW-1:0] r12, r14, r16, rtab;
  logic signed [24:0]    mag;
  logic signed [33:0]    n34;
  logic signed [31:0]    newv;
  logic signed [47:0]    xw, ow;

  assign uc        = nll_pkg::ucode_rom(pc_r);
  assign in_tready = built && (uc.wait_c == nll_pkg::W_IN);
  assign in_acc    = in_tvalid && in_tready;
  assign hold      = ((uc.wait_c == nll_pkg::W_IN) && !in_acc) ||
                     ((uc.wait_c == nll_pkg::W_OUT) && ov_r && !out_tready);
  assign exec      = !hold;

  always_comb begin
    case (uc.jmp_c)
      nll_pkg::J_ALWAYS: jmp = 1'b1;
      nll_pkg::J_LAST:   jmp = (k_r == 2'd3);
      nll_pkg::J_MORE:   jmp = (p_r != P_LAST);
      default:           jmp = 1'b0;
    endcase
  end

  assign pc_nxt = hold ? pc_r : (jmp ? uc.target : pc_r + 5'd1);

  assign a_abs   = arg_r[AW-1] ? AW'(-arg_r) : AW'(arg_r);
  assign sat_idx = |a_abs[AW-1:26];
  assign ra0     = sat_idx ? AB'(TAB_N) : {1'b0, a_abs[25:TAB_SH]};
  assign ra1     = sat_idx ? AB'(TAB_N) : {1'b0, a_abs[25:TAB_SH]} + AB'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wval;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_comb begin
    case (uc.op)
      nll_pkg::OP_MUL_DRV: begin
        ma = MAW'(x_r);
        mb = $signed(MBW'(drive_r));
      end
      nll_pkg::OP_MUL_RES: begin
        ma = MAW'(st_r[3]) + MAW'(s4p_r);
        mb = $signed(MBW'(res_r));
      end
      nll_pkg::OP_TH_MUL: begin
        ma = MAW'($signed({1'b0, rd1_r})) - MAW'($signed({1'b0, rd0_r}));
        mb = $signed(MBW'(frac_r));
      end
      nll_pkg::OP_MUL_G: begin
        ma = MAW'(tgt_r) - MAW'(th_r);
        mb = $signed(MBW'(cutoff_r));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul_p = MPW'(ma) * MPW'(mb);
  assign r12   = rnd_sh(prod_r, 12);
  assign r14   = rnd_sh(prod_r, 14);
  assign r16   = rnd_sh(prod_r, 16);
  assign rtab  = rnd_sh(prod_r, TAB_SH);
  assign mag   = $signed({1'b0, rd0_r}) + $signed(rtab[24:0]);
  assign n34   = 34'(st_r[k_r]) + $signed(r16[33:0]);
  assign newv  = (n34 > S32MAX) ? 32'sh7fff_ffff :
                 (n34 < S32MIN) ? 32'sh8000_0000 : n34[31:0];
  assign xw    = (48'($signed(in_tdata[SAMPLE_BITS-1:0])) <<< IN_UP) >>> IN_DN;
  assign ow    = (48'(st_r[3]) <<< IN_DN) >>> IN_UP;

  always_comb begin
    k_nxt    = k_r;
    p_nxt    = p_r;
    x_nxt    = x_r;
    arg_nxt  = arg_r;
    prod_nxt = prod_r;
    neg_nxt  = neg_r;
    frac_nxt = frac_r;
    th_nxt   = th_r;
    u_nxt    = u_r;
    tgt_nxt  = tgt_r;
    st_nxt   = st_r;
    s4p_nxt  = s4p_r;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    if (exec) begin
      case (uc.op)
        nll_pkg::OP_LOAD: begin
          x_nxt = xw[23:0];
          k_nxt = '0;
          p_nxt = '0;
        end
        nll_pkg::OP_MUL_DRV, nll_pkg::OP_MUL_RES, nll_pkg::OP_TH_MUL,
        nll_pkg::OP_MUL_G: begin
          prod_nxt = mul_p;
        end
        nll_pkg::OP_ARG_DRV: arg_nxt = $signed(r12[AW-1:0]);
        nll_pkg::OP_TH_RD: begin
          neg_nxt  = arg_r[AW-1];
          frac_nxt = a_abs[TAB_SH-1:0];
        end
        nll_pkg::OP_TH_FIN: th_nxt = neg_r ? -mag : mag;
        nll_pkg::OP_SET_U:  u_nxt = th_r;
        nll_pkg::OP_ARG_FB: arg_nxt = AW'(u_r) - $signed(r14[AW-1:0]);
        nll_pkg::OP_SET_TGT: begin
          tgt_nxt = th_r;
          arg_nxt = AW'(st_r[k_r]);
        end
        nll_pkg::OP_UPD: begin
          st_nxt[k_r] = newv;
          arg_nxt     = AW'(newv);
          if (k_r == 2'd3) begin
            s4p_nxt = st_r[3];
          end
          k_nxt = k_r + 2'd1;
        end
        nll_pkg::OP_PASS: begin
          p_nxt = p_r + PW'(1);
          k_nxt = '0;
        end
        nll_pkg::OP_OUT: begin
          ov_nxt = 1'b1;
          od_nxt = (ow > OMAX) ? OMAX[SAMPLE_BITS-1:0] :
                   (ow < OMIN) ? OMIN[SAMPLE_BITS-1:0] : ow[SAMPLE_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= nll_pkg::PC_IDLE;
      ov_r   <= 1'b0;
      st_r   <= '{default: '0};
      s4p_r  <= '0;
      k_r    <= '0;
      p_r    <= '0;
    end else begin
      pc_r   <= pc_nxt;
      ov_r   <= ov_nxt;
      st_r   <= st_nxt;
      s4p_r  <= s4p_nxt;
      k_r    <= k_nxt;
      p_r    <= p_nxt;
    end
    x_r    <= x_nxt;
    arg_r  <= arg_nxt;
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
    frac_r <= frac_nxt;
    th_r   <= th_nxt;
    u_r    <= u_nxt;
    tgt_r  <= tgt_nxt;
    od_r   <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = TDW'(od_r);

endmodule

FILE: rtl/nll_checker.sv
// ----------------------------------------------------------------------------
// nll_checker: port-level checks for the ladder filter
// Watches the stream and register ports and is bound to the top level.
// ----------------------------------------------------------------------------
module nll_checker #(
  parameter int SAMPLE_BITS = nll_pkg::SAMPLE_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  input logic [3:0]                            cfg_paddr,
  input logic [31:0]                           cfg_prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result request dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready again right after a request was taken");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_paddr[3:2] == nll_pkg::REG_RES) |-> cfg_prdata <= 32'(nll_pkg::RES_MAX))
    else $error("resonance register above its limit");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_paddr[3:2] == nll_pkg::REG_DRIVE) |->
      (cfg_prdata >= 32'(nll_pkg::DRIVE_MIN)) && (cfg_prdata <= 32'(nll_pkg::DRIVE_MAX)))
    else $error("drive register outside its limits");

endmodule

bind nonlinear_ladder_lowpass nll_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_nll_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_paddr  (cfg_paddr),
  .cfg_prdata (cfg_prdata)
);

FILE: tb/sv/nonlinear_ladder_lowpass_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonlinear_ladder_lowpass_test: self-checking bench for the ladder filter
// Samples are streamed through the filter under several register settings
// and idle patterns, and every filtered sample is compared with a bit-exact
// fixed-point model of the four-stage oversampled ladder kept in the bench.
// ----------------------------------------------------------------------------
module nonlinear_ladder_lowpass_test;

  localparam int SAMPLE_W = nll_pkg::SAMPLE_BITS_DEF;
  localparam int TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int TANH_BITS = nll_pkg::TANH_TABLE_BITS_DEF;
  localparam int TANH_POINTS = 1 << TANH_BITS;
  localparam int TANH_FRAC = 26 - TANH_BITS;
  localparam int LADDER_PASSES = nll_pkg::OVERSAMPLE_DEF;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint STATE_MAX = 64'sd2147483647;
  localparam longint STATE_MIN = -64'sd2147483648;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = 24'h7F_FFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_BOTTOM = 24'h80_0000;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int RANDOM_RUN = 220;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;    // [23:0] sample_in
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;        // [23:0] sample_out
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  logic [SAMPLE_W-1:0] sample_queue[$];
  logic [SAMPLE_W-1:0] expected_samples[$];
  logic [SAMPLE_W-1:0] held_sample = '0;
  int samples_queued = 0;
  int results_seen = 0;
  int failures = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  logic in_taken = 1'b0;
  logic hold_off_armed = 1'b0;
  int hold_off_count = 0;

  longint tanh_lut[0:TANH_POINTS];
  int cutoff_q16 = int'(nll_pkg::CUTOFF_RESET);
  int res_q13 = int'(nll_pkg::RES_RESET);
  int drive_q12 = int'(nll_pkg::DRIVE_RESET);
  int stage_one = 0;
  int stage_two = 0;
  int stage_three = 0;
  int stage_four = 0;
  int stage_four_last = 0;

  nonlinear_ladder_lowpass dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned q30_product(input longint unsigned a,
                                                  input longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic void build_tanh_lut();
    longint unsigned step;
    longint unsigned sq;
    longint unsigned cube;
    longint unsigned fifth;
    longint unsigned seventh;
    longint unsigned t_step;
    longint unsigned acc;
    longint unsigned den;
    int k;
    step = 64'd1 << (33 - TANH_BITS);
    sq = q30_product(step, step);
    cube = q30_product(sq, step);
    fifth = q30_product(cube, sq);
    seventh = q30_product(fifth, sq);
    t_step = step - cube / 64'd3 + (64'd2 * fifth) / 64'd15 - (64'd17 * seventh) / 64'd315;
    acc = 64'd0;
    tanh_lut[0] = 0;
    for (k = 1; k <= TANH_POINTS; k++) begin
      den = (64'd1 << 30) + q30_product(acc, t_step);
      acc = (((acc + t_step) << 30) + den / 64'd2) / den;
      tanh_lut[k] = longint'((acc + 64'd64) >> 7);
    end
  endfunction

  function automatic longint round_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint tanh_fixed(input longint v);
    longint mag;
    longint lo;
    longint diff;
    longint r;
    int idx;
    mag = (v < 0) ? -v : v;
    if (mag >= (longint'(TANH_POINTS) << TANH_FRAC)) begin
      r = tanh_lut[TANH_POINTS];
    end else begin
      idx = int'(mag >>> TANH_FRAC);
      lo = tanh_lut[idx];
      diff = tanh_lut[idx + 1] - lo;
      r = lo + round_shift(diff * (mag & ((longint'(1) << TANH_FRAC) - 1)), TANH_FRAC);
    end
    return (v < 0) ? -r : r;
  endfunction

  function automatic int ladder_follow(input int y, input longint target);
    longint n;
    n = longint'(y) + round_shift((target - tanh_fixed(y)) * longint'(cutoff_q16), 16);
    if (n > STATE_MAX) n = STATE_MAX;
    if (n < STATE_MIN) n = STATE_MIN;
    return int'(n);
  endfunction

  function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] raw);
    longint x;
    longint u;
    longint fb;
    longint o;
    int p;
    x = $signed(raw);
    u = tanh_fixed(round_shift(x * longint'(drive_q12), 12));
    for (p = 0; p < LADDER_PASSES; p++) begin
      fb = round_shift((longint'(stage_four_last) + longint'(stage_four)) * longint'(res_q13),
                       14);
      stage_one = ladder_follow(stage_one, tanh_fixed(u - fb));
      stage_two = ladder_follow(stage_two, tanh_fixed(stage_one));
      stage_three = ladder_follow(stage_three, tanh_fixed(stage_two));
      stage_four_last = stage_four;
      stage_four = ladder_follow(stage_four, tanh_fixed(stage_three));
    end
    o = stage_four;
    if (o > OUT_MAX) o = OUT_MAX;
    if (o < OUT_MIN) o = OUT_MIN;
    return o[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int v;
    case ($urandom_range(5, 0))
      0, 1: held_sample = SAMPLE_W'($urandom());
      2: begin
        v = int'($urandom_range(131072, 0)) - 65536;
        held_sample = v[SAMPLE_W-1:0];
      end
      3, 4: ;
      default: held_sample = $urandom_range(1, 0) ? SAMPLE_TOP : SAMPLE_BOTTOM;
    endcase
    return held_sample;
  endfunction

  task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_sample(random_sample());
  endtask

  task automatic wait_drained();
    while (results_seen != samples_queued) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input int value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      nll_pkg::REG_CUTOFF: cutoff_q16 = value & 32'h0000_FFFF;
      nll_pkg::REG_RES: begin
        res_q13 = value & 32'h0000_FFFF;
        if (res_q13 > int'(nll_pkg::RES_MAX)) res_q13 = int'(nll_pkg::RES_MAX);
      end
      nll_pkg::REG_DRIVE: begin
        drive_q12 = value & 32'h0000_FFFF;
        if (drive_q12 > int'(nll_pkg::DRIVE_MAX)) drive_q12 = int'(nll_pkg::DRIVE_MAX);
        if (drive_q12 < int'(nll_pkg::DRIVE_MIN)) drive_q12 = int'(nll_pkg::DRIVE_MIN);
      end
      default: ;
    endcase
  endtask

  task automatic set_filter(input int cutoff, input int res, input int drv);
    reg_write(nll_pkg::REG_CUTOFF, cutoff);
    reg_write(nll_pkg::REG_RES, res);
    reg_write(nll_pkg::REG_DRIVE, drv);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= TDATA_W'(sample_queue.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_armed && hold_off_count < HOLD_OFF_CYCLES) begin
      out_tready <= 1'b0;
      hold_off_count <= hold_off_count + 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    logic [SAMPLE_W-1:0] got;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        expected_samples.push_back(filter_sample(in_tdata[SAMPLE_W-1:0]));
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got = out_tdata[SAMPLE_W-1:0];
        if (expected_samples.size() == 0) begin
          $error("sample_out: expected no result, got %0d", $signed(got));
          failures++;
        end else begin
          want = expected_samples.pop_front();
          if (got !== want) begin
            $error("sample_out: expected %0d, got %0d", $signed(want), $signed(got));
            failures++;
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_tanh_lut();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (!in_tready) @(negedge clk);

    reg_write(REG_UNUSED, 32'h0000_1234);
    queue_sample('0);
    repeat (3) queue_sample(SAMPLE_TOP);
    repeat (2) queue_sample(SAMPLE_BOTTOM);
    queue_sample('0);
    queue_sample(24'h00_0001);
    queue_sample(24'hFF_FFFF);
    queue_sample(24'h40_0000);
    queue_sample(24'hC0_0000);
    queue_sample(SAMPLE_TOP);
    wait_drained();

    set_filter(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    repeat (4) queue_sample(SAMPLE_TOP);
    repeat (4) queue_sample(SAMPLE_BOTTOM);
    queue_sample('0);
    queue_sample(24'h00_0001);
    queue_sample(24'hFF_FFFF);
    queue_sample(24'h55_AA55);
    wait_drained();

    set_filter($urandom_range(65535, 0), $urandom_range(nll_pkg::RES_MAX, 0),
               $urandom_range(nll_pkg::DRIVE_MAX, nll_pkg::DRIVE_MIN));
    queue_random(RANDOM_RUN);
    wait_drained();

    set_filter(0, 0, 0);
    src_idle_pct = 74;
    queue_random(RANDOM_RUN);
    wait_drained();

    set_filter($urandom_range(65535, 0), $urandom_range(65535, 0), $urandom_range(65535, 0));
    src_idle_pct = 0;
    sink_stall_pct = 74;
    queue_random(RANDOM_RUN);
    wait_drained();

    set_filter(32'h0000_FFFF, int'(nll_pkg::RES_MAX), int'(nll_pkg::DRIVE_MAX));
    src_idle_pct = 31;
    sink_stall_pct = 31;
    queue_random(RANDOM_RUN);
    wait_drained();

    set_filter(int'(nll_pkg::CUTOFF_RESET), int'(nll_pkg::RES_RESET),
               int'(nll_pkg::DRIVE_RESET));
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_off_armed = 1'b1;
    queue_random(100);
    wait_drained();

    repeat (200) @(negedge clk);
    if (expected_samples.size() != 0) begin
      $error("sample_out: %0d results never arrived", expected_samples.size());
      failures++;
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: nonlinear_ladder_lowpass.f
rtl/nll_pkg.sv
rtl/nonlinear_ladder_lowpass.sv
rtl/nll_checker.sv
tb/sv/nonlinear_ladder_lowpass_test.sv
